@@ rtl/scba_pkg.sv @@
package scba_pkg;

    // pool geometry
    localparam int POOL_BYTES      = 1024;
    localparam int MIN_BLOCK_BYTES = 8;
    localparam int NUM_CLASSES     = 7;

    // field widths
    localparam int SIZE_W   = 12;
    localparam int CLASS_W  = 3;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    // slots in class 0, the widest row of free flags
    localparam int ROW_W   = POOL_BYTES / MIN_BLOCK_BYTES;
    localparam int COUNT_W = $clog2(ROW_W + 1);

    // largest request that may be granted
    localparam int MAX_REQ = POOL_BYTES / 2;

    // slot count of one class
    function automatic int class_count(input int k);
        return ROW_W >> k;
    endfunction

    // first flag bit of one class, classes packed from class 0 up
    function automatic int class_base(input int k);
        int base;
        base = 0;
        for (int j = 0; j < k; j++)
        begin
            base = base + class_count(j);
        end
        return base;
    endfunction

    localparam int FLAG_BITS = class_base(NUM_CLASSES);
    localparam int IDX_W     = $clog2(FLAG_BITS);

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SIZE  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // request kinds
    typedef enum logic {
        ACT_ALLOC   = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    // controller states
    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage

@@ rtl/scba_controller.sv @@
module scba_controller
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output scba_pkg::cmd_t  cmd
);

    scba_pkg::state_t state_reg;
    scba_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // output register can take a new result
    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = scba_pkg::S_SEARCH;
                end
            end
            scba_pkg::S_SEARCH:
            begin
                if (out_free)
                begin
                    state_next = scba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            scba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            scba_pkg::S_SEARCH:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scba_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/scba_datapath.sv @@
module scba_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  scba_pkg::cmd_t                   cmd,
    input  logic                             action,
    input  logic [scba_pkg::SIZE_W-1:0]      request_size,
    input  logic [scba_pkg::CLASS_W-1:0]     release_class,
    input  logic [scba_pkg::SLOT_W-1:0]      release_slot,
    output logic [scba_pkg::STATUS_W-1:0]    status,
    output logic [scba_pkg::CLASS_W-1:0]     granted_class,
    output logic [scba_pkg::SLOT_W-1:0]      granted_slot
);

    localparam int ROWS = 2 ** scba_pkg::CLASS_W;

    // free flags, one per slot of every class
    logic [scba_pkg::FLAG_BITS-1:0] flags_reg;
    logic [scba_pkg::FLAG_BITS-1:0] flags_next;

    // captured item
    logic                            act_reg;
    logic [scba_pkg::CLASS_W-1:0]    cls_reg;
    logic [scba_pkg::SLOT_W-1:0]     slot_reg;
    scba_pkg::status_t               pre_reg;
    logic [scba_pkg::ROW_W-1:0]      row_reg;

    // result registers
    logic [scba_pkg::STATUS_W-1:0]   status_reg;
    logic [scba_pkg::CLASS_W-1:0]    class_reg;
    logic [scba_pkg::SLOT_W-1:0]     gslot_reg;

    logic [scba_pkg::ROW_W-1:0]      row_arr [ROWS];
    logic [scba_pkg::ROW_W-1:0]      row_sel;
    logic                            size_bad;
    logic                            rel_bad;
    logic [scba_pkg::CLASS_W-1:0]    alloc_cls;
    logic [scba_pkg::COUNT_W-1:0]    rel_count;

    logic [scba_pkg::ROW_W-1:0]      lowest;
    logic                            found;
    logic [scba_pkg::SLOT_W-1:0]     enc_slot;
    logic [scba_pkg::SLOT_W-1:0]     tgt_slot;
    logic [scba_pkg::IDX_W-1:0]      flag_idx;
    scba_pkg::status_t               fin_status;

    // rows of flags per class, zero padded above the slot count
    genvar k;
    generate
        for (k = 0; k < ROWS; k++)
        begin : g_row
            if (k < scba_pkg::NUM_CLASSES)
            begin : g_used
                localparam int CNT  = scba_pkg::class_count(k);
                localparam int BASE = scba_pkg::class_base(k);
                if (CNT < scba_pkg::ROW_W)
                begin : g_pad
                    assign row_arr[k] = {{(scba_pkg::ROW_W - CNT){1'b0}},
                                         flags_reg[BASE +: CNT]};
                end
                else
                begin : g_full
                    assign row_arr[k] = flags_reg[BASE +: CNT];
                end
            end
            else
            begin : g_empty
                assign row_arr[k] = '0;
            end
        end
    endgenerate

    // request size to class: smallest block that holds the request
    always_comb
    begin
        alloc_cls = '0;
        for (int j = 0; j < scba_pkg::NUM_CLASSES - 1; j++)
        begin
            if (request_size > scba_pkg::SIZE_W'(scba_pkg::MIN_BLOCK_BYTES << j))
            begin
                alloc_cls = scba_pkg::CLASS_W'(j + 1);
            end
        end
    end

    assign size_bad = (request_size == '0) ||
                      (request_size > scba_pkg::SIZE_W'(scba_pkg::MAX_REQ));

    // release range check
    assign rel_count = scba_pkg::COUNT_W'(scba_pkg::ROW_W) >> release_class;
    assign rel_bad   = (release_class >= scba_pkg::CLASS_W'(scba_pkg::NUM_CLASSES)) ||
                       (scba_pkg::COUNT_W'(release_slot) >= rel_count);

    assign row_sel = row_arr[alloc_cls];

    // capture on input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            row_reg <= row_sel;
            if (action == scba_pkg::ACT_RELEASE)
            begin
                cls_reg  <= release_class;
                slot_reg <= release_slot;
                pre_reg  <= rel_bad ? scba_pkg::ST_RANGE : scba_pkg::ST_OK;
            end
            else
            begin
                cls_reg  <= size_bad ? '0 : alloc_cls;
                slot_reg <= '0;
                pre_reg  <= size_bad ? scba_pkg::ST_SIZE : scba_pkg::ST_OK;
            end
        end
    end

    // lowest free slot of the captured row
    assign lowest = row_reg & (~row_reg + scba_pkg::ROW_W'(1));
    assign found  = |row_reg;

    always_comb
    begin
        enc_slot = '0;
        for (int b = 0; b < scba_pkg::ROW_W; b++)
        begin
            if (lowest[b])
            begin
                enc_slot = enc_slot | scba_pkg::SLOT_W'(b);
            end
        end
    end

    // final status and slot
    always_comb
    begin
        fin_status = pre_reg;
        tgt_slot   = slot_reg;
        if (pre_reg == scba_pkg::ST_OK && act_reg == scba_pkg::ACT_ALLOC)
        begin
            if (found)
            begin
                tgt_slot = enc_slot;
            end
            else
            begin
                fin_status = scba_pkg::ST_FULL;
            end
        end
    end

    // flag index of the target slot
    always_comb
    begin
        flag_idx = '0;
        for (int j = 0; j < scba_pkg::NUM_CLASSES; j++)
        begin
            if (cls_reg == scba_pkg::CLASS_W'(j))
            begin
                flag_idx = scba_pkg::IDX_W'(scba_pkg::class_base(j)) +
                           scba_pkg::IDX_W'(tgt_slot);
            end
        end
    end

    // flag update: allocate clears, release sets
    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.commit && fin_status == scba_pkg::ST_OK)
        begin
            flags_next[flag_idx] = act_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '1;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg <= fin_status;
            class_reg  <= cls_reg;
            gslot_reg  <= tgt_slot;
        end
    end

    assign status        = status_reg;
    assign granted_class = class_reg;
    assign granted_slot  = gslot_reg;

endmodule

@@ rtl/size_class_block_allocator_core.sv @@
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+-------------------------------------------
// request   | in        | in_valid / in_ready | action, request_size, release_class,
//           |           |                     | release_slot
// result    | out       | out_valid/out_ready | status, granted_class, granted_slot
//
// each item is captured with its class row of free flags in the idle state, then
// the search state finds the lowest free slot and updates the flags.
// one item is in work at a time; the next transfer is taken once the result is
// in the output register, even while that result waits.
// a stalled output holds the search cycle until the output register frees up.
// reset clears all free flags to one (every slot free) at once; no sweep.
module size_class_block_allocator_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [scba_pkg::SIZE_W-1:0]      request_size,
    input  logic [scba_pkg::CLASS_W-1:0]     release_class,
    input  logic [scba_pkg::SLOT_W-1:0]      release_slot,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [scba_pkg::STATUS_W-1:0]    status,
    output logic [scba_pkg::CLASS_W-1:0]     granted_class,
    output logic [scba_pkg::SLOT_W-1:0]      granted_slot
);

    scba_pkg::cmd_t cmd;

    // sequencing
    scba_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // flags, class mapping and slot search
    scba_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .request_size  (request_size),
        .release_class (release_class),
        .release_slot  (release_slot),
        .status        (status),
        .granted_class (granted_class),
        .granted_slot  (granted_slot)
    );

endmodule

@@ rtl/scba_checker.sv @@
module scba_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [scba_pkg::STATUS_W-1:0]    status,
    input  logic [scba_pkg::CLASS_W-1:0]     granted_class,
    input  logic [scba_pkg::SLOT_W-1:0]      granted_slot
);

    // a waiting result stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // with an empty output register at the transfer, the result follows without a stall
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |-> ##2 out_valid)
        else $error("result late");

    // out of range status only for a class beyond the last or a slot beyond its class
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == scba_pkg::ST_RANGE |->
            granted_class >= scba_pkg::CLASS_W'(scba_pkg::NUM_CLASSES) ||
            scba_pkg::COUNT_W'(granted_slot) >=
                (scba_pkg::COUNT_W'(scba_pkg::ROW_W) >> granted_class))
        else $error("range status on a valid slot");

    // rejected size carries class 0 slot 0
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == scba_pkg::ST_SIZE |->
            granted_class == '0 && granted_slot == '0)
        else $error("rejected request carries a block");

endmodule

bind size_class_block_allocator_core scba_checker u_scba_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_class (granted_class),
    .granted_slot  (granted_slot)
);

@@ dv/tb.sv @@
module tb;
    import scba_pkg::*;

    localparam int ITEMS_PER_PHASE = 338;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int DRAIN_CYCLES    = 8;

    // one expected result
    typedef struct packed {
        status_t            status;
        logic [CLASS_W-1:0] cls;
        logic [SLOT_W-1:0]  slot;
    } grant_t;

    // free-slot predictor and queue of grants still owed by the block
    class alloc_scoreboard;
        logic [ROW_W-1:0] free_row [NUM_CLASSES];
        grant_t           grants_due [$];
        int               mismatches;
        int               results_seen;
        int               status_seen [4];

        function new();
            foreach (free_row[k])
            begin
                free_row[k] = '1;
            end
            foreach (status_seen[k])
            begin
                status_seen[k] = 0;
            end
            mismatches   = 0;
            results_seen = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        // update the free flags for one accepted request and queue its grant
        function void note_request(action_t act, logic [SIZE_W-1:0] size,
                                   logic [CLASS_W-1:0] rcls, logic [SLOT_W-1:0] rslot);
            grant_t g;
            int     c;
            int     n;
            bit     found;
            g        = '0;
            g.status = ST_OK;
            if (act == ACT_ALLOC)
            begin
                if (size == 0 || size > MAX_REQ)
                begin
                    g.status = ST_SIZE;
                end
                else
                begin
                    // smallest class whose block covers the request
                    c = 0;
                    while ((MIN_BLOCK_BYTES << c) < size)
                    begin
                        c++;
                    end
                    if (c >= NUM_CLASSES)
                    begin
                        g.status = ST_SIZE;
                    end
                    else
                    begin
                        n     = ROW_W >> c;
                        found = 1'b0;
                        g.cls = CLASS_W'(c);
                        for (int s = 0; s < n && !found; s++)
                        begin
                            if (free_row[c][s])
                            begin
                                free_row[c][s] = 1'b0;
                                g.slot         = SLOT_W'(s);
                                found          = 1'b1;
                            end
                        end
                        if (!found)
                        begin
                            g.status = ST_FULL;
                        end
                    end
                end
            end
            else
            begin
                // release echoes its class and slot
                g.cls  = rcls;
                g.slot = rslot;
                if (rcls >= NUM_CLASSES || rslot >= (ROW_W >> rcls))
                begin
                    g.status = ST_RANGE;
                end
                else
                begin
                    free_row[rcls][rslot] = 1'b1;
                end
            end
            grants_due.push_back(g);
        endfunction

        // compare one result transfer with the oldest pending grant
        task check_result(logic [STATUS_W-1:0] st, logic [CLASS_W-1:0] cls,
                          logic [SLOT_W-1:0] slot);
            grant_t want;
            results_seen++;
            if (grants_due.size() == 0)
            begin
                report_mismatch($sformatf("result %0d/%0d/%0d with nothing pending",
                                          st, cls, slot));
                return;
            end
            want = grants_due.pop_front();
            if (st !== want.status)
            begin
                report_mismatch($sformatf("status got %0d want %0d", st, want.status));
            end
            else
            begin
                status_seen[st]++;
            end
            if (cls !== want.cls)
            begin
                report_mismatch($sformatf("granted_class got %0d want %0d", cls, want.cls));
            end
            if (slot !== want.slot)
            begin
                report_mismatch($sformatf("granted_slot got %0d want %0d", slot, want.slot));
            end
        endtask

        // pick a slot that is currently held, starting at a random place
        function bit find_held(output int cls, output int slot);
            int c0;
            int c;
            int n;
            int s0;
            int s;
            c0 = $urandom_range(0, NUM_CLASSES - 1);
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                c  = (c0 + i) % NUM_CLASSES;
                n  = ROW_W >> c;
                s0 = $urandom_range(0, n - 1);
                for (int j = 0; j < n; j++)
                begin
                    s = (s0 + j) % n;
                    if (!free_row[c][s])
                    begin
                        cls  = c;
                        slot = s;
                        return 1'b1;
                    end
                end
            end
            cls  = 0;
            slot = 0;
            return 1'b0;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                action;
    logic [SIZE_W-1:0]   request_size;
    logic [CLASS_W-1:0]  release_class;
    logic [SLOT_W-1:0]   release_slot;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [CLASS_W-1:0]  granted_class;
    logic [SLOT_W-1:0]   granted_slot;

    alloc_scoreboard sb;
    int              idle_pct;
    int              stall_pct;
    int              items_sent;
    int              cycles;

    size_class_block_allocator_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .request_size  (request_size),
        .release_class (release_class),
        .release_slot  (release_slot),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_class (granted_class),
        .granted_slot  (granted_slot)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // cycle count and timeout
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles", cycles);
        $display("*** FAILED ***");
        $finish;
    end

    // result side: check each transfer, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                sb.check_result(status, granted_class, granted_slot);
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // present one request, hold it until transfer, then maybe go idle
    task automatic send_item(action_t act, int size, int rcls, int rslot);
        in_valid      <= 1'b1;
        action        <= act;
        request_size  <= SIZE_W'(size);
        release_class <= CLASS_W'(rcls);
        release_slot  <= SLOT_W'(rslot);
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(act, SIZE_W'(size), CLASS_W'(rcls), SLOT_W'(rslot));
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct)
            begin
                @(posedge clk);
            end
        end
    endtask

    // mostly legal allocates and releases of held slots, some raw noise
    task automatic random_item(int alloc_pct, int top_class);
        int r;
        int c;
        int sz;
        int hc;
        int hs;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            send_item(action_t'($urandom_range(0, 1)), $urandom_range(0, 4095),
                      $urandom_range(0, 7), $urandom_range(0, 127));
        end
        else if (r < 8 + alloc_pct)
        begin
            c  = $urandom_range(0, top_class);
            sz = (c == 0) ? $urandom_range(1, MIN_BLOCK_BYTES)
                          : $urandom_range((MIN_BLOCK_BYTES << (c - 1)) + 1,
                                           MIN_BLOCK_BYTES << c);
            send_item(ACT_ALLOC, sz, $urandom_range(0, 7), $urandom_range(0, 127));
        end
        else if (sb.find_held(hc, hs))
        begin
            send_item(ACT_RELEASE, $urandom_range(0, 4095), hc, hs);
        end
        else
        begin
            send_item(ACT_RELEASE, $urandom_range(0, 4095),
                      $urandom_range(0, NUM_CLASSES - 1), $urandom_range(0, 127));
        end
    endtask

    // main sequence
    initial
    begin
        int phase_idle  [4];
        int phase_stall [4];
        int phase_alloc [4];
        int phase_top   [4];
        phase_idle  = '{0, 47, 0, 36};
        phase_stall = '{0, 0, 47, 36};
        phase_alloc = '{60, 82, 30, 55};
        phase_top   = '{NUM_CLASSES - 1, 2, NUM_CLASSES - 1, NUM_CLASSES - 1};

        sb            = new();
        idle_pct      = 0;
        stall_pct     = 0;
        items_sent    = 0;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        action        <= ACT_ALLOC;
        request_size  <= '0;
        release_class <= '0;
        release_slot  <= '0;
        out_ready     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // size edges and class mapping
        send_item(ACT_ALLOC, 0, 0, 0);
        send_item(ACT_ALLOC, 1, 7, 127);
        send_item(ACT_ALLOC, 8, 0, 0);
        send_item(ACT_ALLOC, 9, 0, 0);
        send_item(ACT_ALLOC, 512, 0, 0);
        send_item(ACT_ALLOC, 257, 0, 0);
        // largest class has only two blocks, so this one finds it full
        send_item(ACT_ALLOC, 300, 0, 0);
        send_item(ACT_ALLOC, 513, 0, 0);
        send_item(ACT_ALLOC, 4095, 0, 0);
        send_item(ACT_ALLOC, 2048, 0, 0);
        // releases out of range, of a free slot, and of held slots
        send_item(ACT_RELEASE, 0, 7, 0);
        send_item(ACT_RELEASE, 0, 6, 2);
        send_item(ACT_RELEASE, 0, 0, 127);
        send_item(ACT_RELEASE, 4095, 6, 0);
        send_item(ACT_ALLOC, 511, 0, 0);
        send_item(ACT_RELEASE, 2730, 3, 127);
        send_item(ACT_RELEASE, 4095, 0, 0);
        send_item(ACT_RELEASE, 0, 7, 127);
        send_item(ACT_ALLOC, 16, 0, 0);
        send_item(ACT_ALLOC, 17, 0, 0);
        send_item(ACT_ALLOC, 64, 0, 0);
        send_item(ACT_ALLOC, 65, 0, 0);
        send_item(ACT_ALLOC, 128, 0, 0);
        send_item(ACT_ALLOC, 129, 0, 0);
        send_item(ACT_ALLOC, 256, 0, 0);

        // random traffic under each idle and stall pattern
        for (int p = 0; p < 4; p++)
        begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            repeat (ITEMS_PER_PHASE) random_item(phase_alloc[p], phase_top[p]);
        end
        in_valid <= 1'b0;

        // wait for outstanding results, then a few quiet cycles
        while (sb.grants_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests over four idle/stall mixes, %0d results checked",
                 items_sent, sb.results_seen);
        $display("outcomes: ok %0d, bad size %0d, class full %0d, out of range %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_SIZE],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_RANGE]);
        if (sb.mismatches == 0 && sb.grants_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
